FILE: hdl/gear_hash_chunk_boundary_macros.svh
// Assertion macros shared by the gear hash chunker checker.
// Depends on a clk and rst in scope at the point of use.
`ifndef GEAR_HASH_CHUNK_BOUNDARY_MACROS_SVH
`define GEAR_HASH_CHUNK_BOUNDARY_MACROS_SVH

// Combinational property, checked at every edge out of reset.
`define GHCB_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("gear chunker check failed");

// Antecedent implies consequent in the following cycle.
`define GHCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gear chunker check failed");

`endif

FILE: hdl/ghcb_pkg.sv
// Package for the gear hash chunker: payload and config types, register
// indexes, cut reason codes and the gear table generator.
package ghcb_pkg;

  localparam int CHUNK_LEN_BITS = 24;
  localparam int OFFSET_BITS    = 48;
  localparam int GEAR_ENTRIES   = 256;
  localparam int HASH_BITS      = 64;
  localparam int CFG_IDX_BITS   = 2;

  localparam logic [HASH_BITS-1:0] GEAR_SEED = 64'h1234_5678_9abc_def0;

  localparam logic [CFG_IDX_BITS-1:0] REG_HASH_MASK = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_LEN   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_LEN   = 2'd2;

  localparam logic [HASH_BITS-1:0]      RST_HASH_MASK = 64'd8191;
  localparam logic [CHUNK_LEN_BITS-1:0] RST_MIN_LEN   = 24'd2048;
  localparam logic [CHUNK_LEN_BITS-1:0] RST_MAX_LEN   = 24'd65536;

  localparam logic [1:0] CUT_HASH = 2'd0;
  localparam logic [1:0] CUT_MAX  = 2'd1;
  localparam logic [1:0] CUT_EOD  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [47:0] boundary_offset;
    logic [1:0]  cut_reason;
  } out_item_t;

  typedef struct packed {
    logic [HASH_BITS-1:0]      hash_mask;
    logic [CHUNK_LEN_BITS-1:0] min_len;
    logic [CHUNK_LEN_BITS-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [HASH_BITS-1:0] gear;
    logic                 eod;
  } gear_item_t;

  // xorshift 13/7/17 from the fixed seed; entry idx is the value after idx+1 steps
  function automatic logic [HASH_BITS-1:0] gear_value(input int idx);
    logic [HASH_BITS-1:0] v;
    v = GEAR_SEED;
    for (int k = 0; k <= idx; k++) begin
      v = v ^ (v << 13);
      v = v ^ (v >> 7);
      v = v ^ (v << 17);
    end
    return v;
  endfunction

endpackage

FILE: hdl/ghcb_cfg_regs.sv
// Configuration registers of the gear hash chunker.
// Depends on ghcb_pkg.
module ghcb_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ghcb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [ghcb_pkg::HASH_BITS-1:0]      cfg_data,
  output ghcb_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hash_mask <= ghcb_pkg::RST_HASH_MASK;
      cfg.min_len   <= ghcb_pkg::RST_MIN_LEN;
      cfg.max_len   <= ghcb_pkg::RST_MAX_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ghcb_pkg::REG_HASH_MASK: cfg.hash_mask <= cfg_data;
        ghcb_pkg::REG_MIN_LEN:   cfg.min_len <= cfg_data[ghcb_pkg::CHUNK_LEN_BITS-1:0];
        ghcb_pkg::REG_MAX_LEN:   cfg.max_len <= cfg_data[ghcb_pkg::CHUNK_LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/ghcb_gear_stage.sv
// Input register of the gear hash chunker: takes a byte transfer and
// registers its gear table value. Depends on ghcb_pkg.
module ghcb_gear_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ghcb_pkg::in_item_t   in_data,
  input  logic                 take,
  output ghcb_pkg::gear_item_t item
);

  logic                          load;
  logic [ghcb_pkg::HASH_BITS-1:0] gear_rom [ghcb_pkg::GEAR_ENTRIES];

  for (genvar k = 0; k < ghcb_pkg::GEAR_ENTRIES; k++) begin : g_rom
    assign gear_rom[k] = ghcb_pkg::gear_value(k);
  end

  assign load     = !item.valid || take;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (load) begin
      item.valid <= in_valid;
      if (in_valid) begin
        item.gear <= gear_rom[in_data.data_byte];
        item.eod  <= in_data.end_of_data;
      end
    end
  end

endmodule

FILE: hdl/ghcb_cut_stage.sv
// Hash update, cut decision and result register of the gear hash chunker.
// Depends on ghcb_pkg.
module ghcb_cut_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  ghcb_pkg::cfg_t        cfg,
  input  ghcb_pkg::gear_item_t  item,
  output logic                  take,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ghcb_pkg::out_item_t   out_data
);

  logic [ghcb_pkg::HASH_BITS-1:0]      hash, hash_next, hash_upd;
  logic [ghcb_pkg::CHUNK_LEN_BITS-1:0] len, len_next, len_inc;
  logic [ghcb_pkg::OFFSET_BITS-1:0]    pos, pos_next, pos_inc;
  logic hit, cut, emit;
  logic [1:0] reason;

  assign take = item.valid && (!out_valid || !out_stall);

  always_comb begin
    hash_upd = {hash[ghcb_pkg::HASH_BITS-2:0], 1'b0} + item.gear;
    len_inc  = (&len) ? len : len + 1'b1;
    pos_inc  = pos + 1'b1;
    hit      = (hash_upd & cfg.hash_mask) == '0;
    cut      = (len_inc >= cfg.min_len) && (hit || (len_inc >= cfg.max_len));
    emit     = cut || item.eod;
    reason   = !cut ? ghcb_pkg::CUT_EOD : (hit ? ghcb_pkg::CUT_HASH : ghcb_pkg::CUT_MAX);
    if (item.eod) begin
      hash_next = '0;
      len_next  = '0;
      pos_next  = '0;
    end else if (cut) begin
      hash_next = '0;
      len_next  = '0;
      pos_next  = pos_inc;
    end else begin
      hash_next = hash_upd;
      len_next  = len_inc;
      pos_next  = pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash      <= '0;
      len       <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else if (take) begin
      hash      <= hash_next;
      len       <= len_next;
      pos       <= pos_next;
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_data.boundary_offset <= pos_inc[47:0];
      out_data.cut_reason      <= reason;
    end
  end

endmodule

FILE: hdl/gear_hash_chunk_boundary.sv
// Gear hash content-defined chunker. Takes one stream byte per cycle and
// reports each chunk end (offset just past the last byte, and why it was cut)
// through the gear register and the result register; the rate is set by the
// hash shift-add and compare loop, one byte per clock sustained, with the
// input stalled only while a finished result is held by out_stall.
// Depends on ghcb_pkg, ghcb_cfg_regs, ghcb_gear_stage, ghcb_cut_stage.
module gear_hash_chunk_boundary (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ghcb_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ghcb_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [ghcb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [ghcb_pkg::HASH_BITS-1:0]      cfg_data
);

  ghcb_pkg::cfg_t       cfg;
  ghcb_pkg::gear_item_t item;
  logic                 take;

  ghcb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ghcb_gear_stage u_gear (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .take     (take),
    .item     (item)
  );

  ghcb_cut_stage u_cut (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/ghcb_checker.sv
// Port-level checker for the gear hash chunker, bound to the top level.
// Depends on ghcb_pkg and the macro header.
`include "gear_hash_chunk_boundary_macros.svh"

module ghcb_props (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input ghcb_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input ghcb_pkg::out_item_t out_data
);

  `GHCB_ASSERT(a_stall_only_when_blocked, !in_stall || (out_valid && out_stall))
  `GHCB_ASSERT(a_reason_known, !out_valid || out_data.cut_reason != 2'd3)
  `GHCB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `GHCB_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

endmodule

bind gear_hash_chunk_boundary ghcb_props u_ghcb_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: bench/ghcb_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the gear hash chunker: follows register writes and input
// transfers, predicts each chunk cut and compares it with the output transfers.
// Depends on ghcb_pkg.
module ghcb_checker
  import ghcb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  in_item_t                in_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  out_item_t               out_data,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [HASH_BITS-1:0]    cfg_data,
  output int                      error_count,
  output int                      cuts_pending
);

  logic [HASH_BITS-1:0]      gear_lut [GEAR_ENTRIES];
  cfg_t                      cfg;
  logic [HASH_BITS-1:0]      hash_acc;
  logic [CHUNK_LEN_BITS-1:0] chunk_len;
  logic [OFFSET_BITS-1:0]    stream_pos;
  out_item_t                 expected_cuts [$];
  int                        mismatches = 0;
  int                        pend = 0;

  assign error_count  = mismatches;
  assign cuts_pending = pend;

  initial begin
    logic [HASH_BITS-1:0] v;
    v = GEAR_SEED;
    for (int k = 0; k < GEAR_ENTRIES; k++) begin
      v = v ^ (v << 13);
      v = v ^ (v >> 7);
      v = v ^ (v << 17);
      gear_lut[k] = v;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t: chunk cut mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Advances the chunker by one byte; returns 1 when the byte closes a chunk.
  function automatic logic next_cut(input in_item_t item, output out_item_t cut);
    logic hit;
    logic found;
    found = 1'b0;
    cut   = '0;
    hash_acc = (hash_acc << 1) + gear_lut[item.data_byte];
    if (chunk_len != '1) chunk_len++;
    stream_pos++;
    if (chunk_len >= cfg.min_len) begin
      hit = (hash_acc & cfg.hash_mask) == '0;
      if (hit || chunk_len >= cfg.max_len) begin
        cut.boundary_offset = stream_pos;
        cut.cut_reason      = hit ? CUT_HASH : CUT_MAX;
        found     = 1'b1;
        hash_acc  = '0;
        chunk_len = '0;
      end
    end
    if (item.end_of_data) begin
      if (!found && chunk_len != '0) begin
        cut.boundary_offset = stream_pos;
        cut.cut_reason      = CUT_EOD;
        found = 1'b1;
      end
      hash_acc   = '0;
      chunk_len  = '0;
      stream_pos = '0;
    end
    return found;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cfg        = '{hash_mask: RST_HASH_MASK, min_len: RST_MIN_LEN, max_len: RST_MAX_LEN};
      hash_acc   = '0;
      chunk_len  = '0;
      stream_pos = '0;
      expected_cuts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HASH_MASK: cfg.hash_mask = cfg_data;
          REG_MIN_LEN:   cfg.min_len   = cfg_data[CHUNK_LEN_BITS-1:0];
          REG_MAX_LEN:   cfg.max_len   = cfg_data[CHUNK_LEN_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_cuts.size() == 0) begin
          report_mismatch($sformatf("unexpected cut at offset %0d reason %0d",
                                    out_data.boundary_offset, out_data.cut_reason));
        end else begin
          want = expected_cuts.pop_front();
          if (out_data.boundary_offset !== want.boundary_offset)
            report_mismatch($sformatf("offset %0d, expected %0d",
                                      out_data.boundary_offset, want.boundary_offset));
          if (out_data.cut_reason !== want.cut_reason)
            report_mismatch($sformatf("reason %0d at offset %0d, expected %0d",
                                      out_data.cut_reason, want.boundary_offset,
                                      want.cut_reason));
        end
      end
      if (in_valid && !in_stall) begin
        if (next_cut(in_data, want)) expected_cuts.push_back(want);
      end
    end
    pend <= expected_cuts.size();
  end

endmodule

FILE: bench/gear_hash_chunk_boundary_tb.sv
`timescale 1ns / 1ps
// Top of the gear hash chunker bench: clock, reset, byte stimulus, output
// stall pattern, watchdog and verdict. Depends on ghcb_pkg, ghcb_checker and the DUT.
module gear_hash_chunk_boundary_tb;
  import ghcb_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int ITEM_TARGET  = 850;
  localparam int SETTLE_EXTRA = 6;

  localparam logic [CFG_IDX_BITS-1:0]   REG_SPARE = 2'd3;
  localparam logic [HASH_BITS-1:0]      MASK_ALL  = '1;
  localparam logic [HASH_BITS-1:0]      MASK_NONE = '0;
  localparam logic [CHUNK_LEN_BITS-1:0] LEN_TOP   = '1;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  in_item_t                in_data = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  out_item_t               out_data;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_HASH_MASK;
  logic [HASH_BITS-1:0]    cfg_data = '0;

  int error_count;
  int cuts_pending;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  int burst_left = 1;
  bit offering = 1'b0;
  bit idle_gaps = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gear_hash_chunk_boundary u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ghcb_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .error_count  (error_count),
    .cuts_pending (cuts_pending)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output stall pattern; a hold request freezes the output for a long stretch.
  initial begin
    stall_mode_t mode;
    int          left;
    mode = STALL_NONE;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 120);
        end
        left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ((left % 8) < 3);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    in_data  <= '{data_byte: b, end_of_data: eod};
    in_valid <= 1'b1;
    offering = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = idle_gaps ? $urandom_range(0, 10) : 0;
      if (idle_gaps && $urandom_range(0, 15) == 0) gap = $urandom_range(20, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every predicted cut has been transferred.
  task automatic settle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (cuts_pending != 0) @(posedge clk);
    repeat (SETTLE_EXTRA) @(posedge clk);
  endtask

  function automatic logic [HASH_BITS-1:0] pad_len(input logic [CHUNK_LEN_BITS-1:0] len);
    return {32'($urandom), 8'($urandom), len};
  endfunction

  task automatic program_regs(input logic [HASH_BITS-1:0] mask,
                              input logic [CHUNK_LEN_BITS-1:0] min_len,
                              input logic [CHUNK_LEN_BITS-1:0] max_len);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HASH_MASK;
    cfg_data  <= mask;
    @(posedge clk);
    cfg_index <= REG_MIN_LEN;
    cfg_data  <= pad_len(min_len);
    @(posedge clk);
    cfg_index <= REG_MAX_LEN;
    cfg_data  <= pad_len(max_len);
    @(posedge clk);
    // unmapped index, must be ignored
    cfg_index <= REG_SPARE;
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [HASH_BITS-1:0]      mask;
    logic [CHUNK_LEN_BITS-1:0] min_len;
    logic [CHUNK_LEN_BITS-1:0] max_len;
    int                        phase;
    int                        quota;
    int                        sent;
    int                        run_len;
    bit                        noisy;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: short streams end only on end of data
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h01, 1'b1);

    // zero minimum acts as one; a hash cut on the last byte hides the end cut
    settle();
    program_regs(MASK_NONE, 24'd0, 24'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);

    // hash match and length limit on the same byte
    settle();
    program_regs(MASK_NONE, 24'd2, 24'd2);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);

    // zero maximum: cut as soon as the minimum is reached
    settle();
    program_regs(MASK_ALL, 24'd3, 24'd0);
    for (int i = 0; i < 7; i++) send_byte(8'($urandom_range(0, 255)), i == 6);

    // maximum below minimum
    settle();
    program_regs(MASK_ALL, 24'd4, 24'd2);
    for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(0, 255)), i == 4);

    // largest lengths
    settle();
    program_regs(MASK_ALL, LEN_TOP, LEN_TOP);
    for (int i = 0; i < 3; i++) send_byte(8'($urandom_range(0, 255)), i == 2);

    phase = 0;
    while (bytes_sent < ITEM_TARGET) begin
      settle();
      phase++;
      min_len = 24'($urandom_range(1, 8));
      max_len = 24'($urandom_range(0, 24));
      mask    = '0;
      repeat ($urandom_range(1, 4)) mask[$urandom_range(0, HASH_BITS-1)] = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          mask    = MASK_ALL;
          max_len = LEN_TOP;
        end
        1: mask = MASK_NONE;
        2: begin
          min_len = '0;
          max_len = '0;
        end
        default: ;
      endcase
      noisy     = ($urandom_range(0, 4) == 0);
      idle_gaps = ($urandom_range(0, 3) != 0);
      quota     = $urandom_range(40, 110);
      if (phase == 3) begin
        // every byte cuts while the output is held off
        mask      = MASK_NONE;
        min_len   = 24'd1;
        max_len   = 24'd1;
        noisy     = 1'b0;
        idle_gaps = 1'b0;
        quota     = 150;
      end
      program_regs(mask, min_len, max_len);
      if (phase == 3) hold_req = 1'b1;
      sent = 0;
      while (sent < quota) begin
        if (noisy) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          sent++;
        end else begin
          run_len = $urandom_range(1, 40);
          for (int i = 0; i < run_len; i++)
            send_byte(8'($urandom_range(0, 255)), i == run_len - 1);
          sent += run_len;
        end
      end
    end

    settle();
    if (error_count == 0 && cuts_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/ghcb_pkg.sv
hdl/ghcb_cfg_regs.sv
hdl/ghcb_gear_stage.sv
hdl/ghcb_cut_stage.sv
hdl/gear_hash_chunk_boundary.sv
hdl/ghcb_checker.sv
bench/ghcb_checker.sv
bench/gear_hash_chunk_boundary_tb.sv
